[rtl/aes_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// aes_pkg: shared constants and AES round functions
// S-box tables, round transforms and key schedule helpers.
// ----------------------------------------------------------------------------
package aes_pkg;

    localparam int BLOCK_BYTES_DEF = 16;
    localparam int NUM_ROUNDS      = 10;
    localparam int RK_WORDS        = 2 * (NUM_ROUNDS + 1);

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] ISBOX [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    // byte i of a block sits at bits 127-8i
    function automatic logic [7:0] get_b(input logic [127:0] s, input int i);
        get_b = s[127-8*i -: 8];
    endfunction

    function automatic logic [7:0] xt(input logic [7:0] a);
        xt = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // forward round without key add; mix selects MixColumns
    function automatic logic [127:0] enc_round(input logic [127:0] s, input logic mix);
        logic [7:0] t [16];
        logic [7:0] a0, a1, a2, a3;
        logic [127:0] o;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                t[r+4*c] = SBOX[get_b(s, r + 4*((c+r) & 3))];
        for (int c = 0; c < 4; c++) begin
            a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
            if (mix) begin
                t[4*c]   = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
                t[4*c+1] = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
                t[4*c+2] = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
                t[4*c+3] = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
            end
        end
        for (int i = 0; i < 16; i++) o[127-8*i -: 8] = t[i];
        enc_round = o;
    endfunction

    // inverse shift and sub bytes
    function automatic logic [127:0] dec_sub(input logic [127:0] s);
        logic [127:0] o;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                o[127-8*(r+4*c) -: 8] = ISBOX[get_b(s, r + 4*((c-r+4) & 3))];
        dec_sub = o;
    endfunction

    function automatic logic [127:0] inv_mix(input logic [127:0] s);
        logic [7:0] a [4];
        logic [7:0] x2 [4];
        logic [7:0] x4 [4];
        logic [7:0] x8 [4];
        logic [127:0] o;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                a[r]  = get_b(s, 4*c+r);
                x2[r] = xt(a[r]);
                x4[r] = xt(x2[r]);
                x8[r] = xt(x4[r]);
            end
            for (int r = 0; r < 4; r++)
                o[127-8*(4*c+r) -: 8] =
                    (x8[r] ^ x4[r] ^ x2[r]) ^
                    (x8[(r+1)&3] ^ x2[(r+1)&3] ^ a[(r+1)&3]) ^
                    (x8[(r+2)&3] ^ x4[(r+2)&3] ^ a[(r+2)&3]) ^
                    (x8[(r+3)&3] ^ a[(r+3)&3]);
        end
        inv_mix = o;
    endfunction

    // next round key from previous one
    function automatic logic [127:0] key_next(input logic [127:0] k, input logic [7:0] rc);
        logic [31:0] w0, w1, w2, w3, t;
        w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
        t = {SBOX[w3[23:16]] ^ rc, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
        w0 = w0 ^ t;
        w1 = w1 ^ w0;
        w2 = w2 ^ w1;
        w3 = w3 ^ w2;
        key_next = {w0, w1, w2, w3};
    endfunction

endpackage
`default_nettype wire

[rtl/aes_rkmem.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// aes_rkmem: round key memory
// One 128-bit row per round key, one write and one registered read port.
// A read of the row being written returns the new data.
// ----------------------------------------------------------------------------
module aes_rkmem
    import aes_pkg::*;
#(
    parameter int DEPTH = NUM_ROUNDS + 1
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [127:0]             i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [127:0]                  o_rdata
);

    logic [127:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // write-first forwarding on a same-row access
        if (i_we && i_waddr == i_raddr) begin
            o_rdata <= i_wdata;
        end else begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

[rtl/aes128_cbc_codec.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// aes128_cbc_codec: AES-128 CBC codec with PKCS#7 padding
// Usage: write key_hi (0x0) and key_lo (0x8) over APB while idle. Feed items
// on the input channel: an item with start_req loads the IV (echoed as c0
// when encrypting, zero result with out_bytes 0 when decrypting); later items
// are data blocks, final_req on the last one. Each item gives one result.
// An IV item's result is valid the cycle after it is taken, so IV items
// can go one per cycle while the receiver takes each result. A data block
// passes the whitening load, ten AES rounds at one per cycle from the round
// key memory and a finish step before its result is registered; the next
// item is taken once the block is back in idle. The first data block after
// a key write also runs the key schedule first, one round key per cycle.
// One item is in work at a time; the next is taken once the output register
// is free or being read. A stalled receiver holds the result register and
// the next item waits.
// Reset clears the chain value to zero and marks the key schedule stale;
// the round key memory needs no clearing, it is rebuilt before any use.
// ----------------------------------------------------------------------------
module aes128_cbc_codec
    import aes_pkg::*;
#(
    parameter int BLOCK_BYTES = BLOCK_BYTES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic [63:0]      prdata,
    output logic             pready,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic        i_operation,
    input  wire logic        i_start_req,
    input  wire logic        i_final_req,
    input  wire logic [4:0]  i_byte_count,
    input  wire logic [63:0] i_block_hi,
    input  wire logic [63:0] i_block_lo,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [63:0]      o_out_hi,
    output logic [63:0]      o_out_lo,
    output logic [4:0]       o_out_bytes,
    output logic             o_is_last,
    output logic             o_pad_error
);

    localparam int BW = 8 * BLOCK_BYTES;
    localparam int AW = $clog2(NUM_ROUNDS + 1);
    localparam logic [3:0] ADDR_KEY_HI = 4'h0;
    localparam logic [3:0] ADDR_KEY_LO = 4'h8;

    typedef enum logic [2:0] {S_IDLE, S_KEYS, S_PRIME, S_RUN, S_DONE} t_state;

    t_state        r_state;
    logic [63:0]   r_key_hi, r_key_lo;
    logic          r_keys_ready;
    logic [BW-1:0] r_chain, r_blk, r_st, r_kexp;
    logic [AW-1:0] r_cnt;
    logic [7:0]    r_rc;
    logic          r_dec, r_fin;
    logic [BW-1:0] r_out;
    logic [4:0]    r_obytes;
    logic          r_olast, r_operr, r_ovalid;

    logic          wr;
    logic          ld_out;
    logic          rk_we;
    logic [AW-1:0] rk_waddr, rk_raddr;
    logic [BW-1:0] rk;

    // APB
    assign pready = 1'b1;
    assign wr = psel && penable && pwrite;
    always_comb begin
        unique case (paddr)
            ADDR_KEY_HI: prdata = r_key_hi;
            ADDR_KEY_LO: prdata = r_key_lo;
            default:     prdata = '0;
        endcase
    end

    aes_rkmem #(.DEPTH(NUM_ROUNDS + 1)) u_rkmem (
        .i_clk  (i_clk),
        .i_we   (rk_we),
        .i_waddr(rk_waddr),
        .i_wdata(r_kexp),
        .i_raddr(rk_raddr),
        .o_rdata(rk)
    );

    assign rk_we    = (r_state == S_KEYS);
    assign rk_waddr = r_cnt;

    // read address: round key needed in the next cycle
    always_comb begin
        unique case (r_state)
            S_IDLE:  rk_raddr = i_operation ? AW'(NUM_ROUNDS) : '0;
            S_KEYS:  rk_raddr = r_dec ? AW'(NUM_ROUNDS) : '0;
            S_PRIME: rk_raddr = r_dec ? AW'(NUM_ROUNDS - 1) : AW'(1);
            S_RUN: begin
                if (r_cnt == AW'(NUM_ROUNDS - 1))
                    rk_raddr = '0;
                else
                    rk_raddr = r_dec ? AW'(NUM_ROUNDS - 2) - r_cnt : r_cnt + AW'(2);
            end
            default: rk_raddr = '0;
        endcase
    end

    assign o_ready = (r_state == S_IDLE) && (!r_ovalid || i_ready);

    // result register loads on an IV item or a finished block
    assign ld_out = (r_state == S_IDLE && i_valid && o_ready && i_start_req) ||
                    (r_state == S_DONE);

    // padded plaintext for encryption
    logic [BW-1:0] pin;
    logic [4:0]    n;
    always_comb begin
        n = (i_byte_count >= 5'd16) ? 5'd15 : i_byte_count;
        pin = {i_block_hi, i_block_lo};
        if (!i_operation && i_final_req)
            for (int i = 0; i < BLOCK_BYTES; i++)
                if (5'(i) >= n) pin[BW-1-8*i -: 8] = 8'(5'd16 - n);
    end

    // round datapath
    logic [BW-1:0] rnd;
    logic [BW-1:0] dsub;
    always_comb begin
        dsub = dec_sub(r_st) ^ rk;
        if (r_dec)
            rnd = (r_cnt == AW'(NUM_ROUNDS - 1)) ? dsub : inv_mix(dsub);
        else
            rnd = enc_round(r_st, r_cnt != AW'(NUM_ROUNDS - 1)) ^ rk;
    end

    // decrypt finish with pad check
    logic [BW-1:0] pt;
    logic [7:0]    pad;
    logic          perr;
    logic [4:0]    pbytes;
    always_comb begin
        pt = r_st ^ r_chain;
        pad = pt[7:0];
        perr = 1'b0;
        pbytes = 5'd16;
        if (r_fin) begin
            if (pad == 8'd0 || pad > 8'd16) begin
                perr = 1'b1;
                pbytes = 5'd0;
            end else begin
                pbytes = 5'(9'd16 - {1'b0, pad});
                for (int i = 0; i < BLOCK_BYTES; i++)
                    if (9'(i) >= 9'd16 - {1'b0, pad}) pt[BW-1-8*i -: 8] = 8'h00;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_key_hi     <= '0;
            r_key_lo     <= '0;
            r_keys_ready <= 1'b0;
            r_chain      <= '0;
            r_ovalid     <= 1'b0;
            r_cnt        <= '0;
        end else begin
            if (wr && paddr == ADDR_KEY_HI) r_key_hi <= pwdata;
            if (wr && paddr == ADDR_KEY_LO) r_key_lo <= pwdata;
            // a key write marks the schedule stale
            if (wr && (paddr == ADDR_KEY_HI || paddr == ADDR_KEY_LO))
                r_keys_ready <= 1'b0;
            else if (r_state == S_KEYS && r_cnt == AW'(NUM_ROUNDS))
                r_keys_ready <= 1'b1;
            // output valid
            if (ld_out) r_ovalid <= 1'b1;
            else if (r_ovalid && i_ready) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: if (i_valid && o_ready) begin
                    r_dec  <= i_operation;
                    r_fin  <= i_final_req;
                    r_blk  <= {i_block_hi, i_block_lo};
                    r_st   <= i_operation ? {i_block_hi, i_block_lo} : pin ^ r_chain;
                    r_cnt  <= '0;
                    r_kexp <= {r_key_hi, r_key_lo};
                    r_rc   <= 8'h01;
                    if (i_start_req) begin
                        // IV item: result right away, no rounds
                        r_chain  <= {i_block_hi, i_block_lo};
                        r_out    <= i_operation ? '0 : {i_block_hi, i_block_lo};
                        r_obytes <= i_operation ? 5'd0 : 5'd16;
                        r_olast  <= 1'b0;
                        r_operr  <= 1'b0;
                    end else begin
                        r_state <= r_keys_ready ? S_PRIME : S_KEYS;
                    end
                end
                S_KEYS: begin
                    // write round key r_cnt, derive the next
                    r_kexp <= key_next(r_kexp, r_rc);
                    r_rc   <= xt(r_rc);
                    if (r_cnt == AW'(NUM_ROUNDS)) begin
                        r_cnt   <= '0;
                        r_state <= S_PRIME;
                    end else begin
                        r_cnt <= r_cnt + AW'(1);
                    end
                end
                S_PRIME: begin
                    // whitening key is on the read port
                    r_st    <= r_st ^ rk;
                    r_state <= S_RUN;
                end
                S_RUN: begin
                    r_st <= rnd;
                    if (r_cnt == AW'(NUM_ROUNDS - 1)) r_state <= S_DONE;
                    else r_cnt <= r_cnt + AW'(1);
                end
                S_DONE: begin
                    r_olast  <= r_fin;
                    r_cnt    <= '0;
                    r_state  <= S_IDLE;
                    if (r_dec) begin
                        r_out    <= pt;
                        r_obytes <= pbytes;
                        r_operr  <= perr;
                        r_chain  <= r_blk;
                    end else begin
                        r_out    <= r_st;
                        r_obytes <= 5'd16;
                        r_operr  <= 1'b0;
                        r_chain  <= r_st;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // result outputs straight from the output register
    assign o_valid     = r_ovalid;
    assign o_out_hi    = r_out[BW-1 -: 64];
    assign o_out_lo    = r_out[63:0];
    assign o_out_bytes = r_obytes;
    assign o_is_last   = r_olast;
    assign o_pad_error = r_operr;

    // assertions
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_ready)
        else $error("input accepted while busy");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> $stable(r_out))
        else $error("result changed under stall");
    a_run_keys: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> r_keys_ready)
        else $error("round without key schedule");

endmodule
`default_nettype wire
